@@ src/fqrb_pkg.sv @@
// ----------------------------------------------------------------------------
// fqrb_pkg
// Shared types and constants for the fastq record boundary finder.
// ----------------------------------------------------------------------------
package fqrb_pkg;

  localparam int LENGTH_BITS_DEF = 20;
  localparam int OFFSET_BITS_DEF = 48;
  localparam int OFFSET_W        = 48;

  // first-character class of a line
  typedef enum logic [1:0] {
    CLS_EMPTY = 2'd0,
    CLS_AT    = 2'd1,
    CLS_PLUS  = 2'd2,
    CLS_OTHER = 2'd3
  } line_class_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_stream;
    logic       start_scan;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] record_offset;
    logic                length_saturated;
  } out_item_t;

  // decision handed from the scan core to the result stage
  typedef struct packed {
    logic emit;
    logic found;
    logic sat;
  } decide_t;

endpackage

@@ src/fastq_record_boundary_finder.sv @@
// ----------------------------------------------------------------------------
// fastq_record_boundary_finder
// Scans a chunk byte by byte and reports the absolute offset of its first
// FASTQ record, or that none exists.
// ----------------------------------------------------------------------------
// One byte per transaction, one transaction per cycle sustained. A transaction
// is held in an input register; the window update runs on it when the output
// register can take a result, and any result lands in that output register.
// Input ready drops only while the output register holds a result that the
// consumer has not taken. Each scan gives at most one result, after which
// transactions are ignored until one with start_scan set.
// base_offset must be written while the block is idle.
module fastq_record_boundary_finder #(
  parameter int LENGTH_BITS = fqrb_pkg::LENGTH_BITS_DEF,
  parameter int OFFSET_BITS = fqrb_pkg::OFFSET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fqrb_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fqrb_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [fqrb_pkg::OFFSET_W-1:0] cfg_wdata
);
  import fqrb_pkg::*;

  in_item_t               item_r;
  logic                   item_valid_r;
  logic                   can_take;
  logic                   fire;
  decide_t                dec;
  logic [OFFSET_BITS-1:0] rel_start;

  assign fire     = item_valid_r && can_take;
  assign in_ready = !item_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  fqrb_scan_core #(
    .LENGTH_BITS (LENGTH_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item_r),
    .dec       (dec),
    .rel_start (rel_start)
  );

  fqrb_result_stage #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .dec       (dec),
    .rel_start (rel_start),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ src/fqrb_scan_core.sv @@
// ----------------------------------------------------------------------------
// fqrb_scan_core
// Line window and per-byte update: splits lines, trims carriage returns,
// checks the four-line record pattern and decides at end of stream.
// ----------------------------------------------------------------------------
module fqrb_scan_core #(
  parameter int LENGTH_BITS = fqrb_pkg::LENGTH_BITS_DEF,
  parameter int OFFSET_BITS = fqrb_pkg::OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  fqrb_pkg::in_item_t     item,
  output fqrb_pkg::decide_t      dec,
  output logic [OFFSET_BITS-1:0] rel_start
);
  import fqrb_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [7:0] CHR_LF   = 8'h0A;
  localparam logic [7:0] CHR_CR   = 8'h0D;
  localparam logic [7:0] CHR_AT   = 8'h40;
  localparam logic [7:0] CHR_PLUS = 8'h2B;

  // completed lines, oldest first, plus the line being received
  line_class_t            slot_class_r [3];
  logic [LENGTH_BITS-1:0] slot_len_r   [3];
  logic [OFFSET_BITS-1:0] slot_start_r [3];
  logic [1:0]             held_r;
  line_class_t            cur_class_r;
  logic [LENGTH_BITS-1:0] cur_len_r;
  logic [OFFSET_BITS-1:0] cur_start_r;
  logic [LENGTH_BITS-1:0] cr_run_r;
  logic [OFFSET_BITS-1:0] pos_r;
  logic                   done_r;

  line_class_t            slot_class_nxt [3];
  logic [LENGTH_BITS-1:0] slot_len_nxt   [3];
  logic [OFFSET_BITS-1:0] slot_start_nxt [3];
  logic [1:0]             held_nxt;
  line_class_t            cur_class_nxt;
  logic [LENGTH_BITS-1:0] cur_len_nxt;
  logic [OFFSET_BITS-1:0] cur_start_nxt;
  logic [LENGTH_BITS-1:0] cr_run_nxt;
  logic [OFFSET_BITS-1:0] pos_nxt;
  logic                   done_nxt;

  logic                   finish;
  logic                   hit;
  logic [LENGTH_BITS-1:0] cr_inc;
  logic [LENGTH_BITS:0]   len_sum;

  function automatic line_class_t classify(input logic [7:0] b);
    line_class_t c;
    if (b == CHR_AT) begin
      c = CLS_AT;
    end else if (b == CHR_PLUS) begin
      c = CLS_PLUS;
    end else begin
      c = CLS_OTHER;
    end
    return c;
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      slot_class_nxt[i] = slot_class_r[i];
      slot_len_nxt[i]   = slot_len_r[i];
      slot_start_nxt[i] = slot_start_r[i];
    end
    held_nxt      = held_r;
    cur_class_nxt = cur_class_r;
    cur_len_nxt   = cur_len_r;
    cur_start_nxt = cur_start_r;
    cr_run_nxt    = cr_run_r;
    pos_nxt       = pos_r;
    done_nxt      = done_r;
    dec           = '0;
    rel_start     = '0;
    finish        = 1'b0;
    hit           = 1'b0;
    cr_inc        = (cr_run_r == LEN_MAX) ? LEN_MAX : cr_run_r + 1'b1;
    len_sum       = '0;

    // new scan wipes the window before this transaction is taken
    if (item.start_scan) begin
      for (int i = 0; i < 3; i++) begin
        slot_class_nxt[i] = CLS_EMPTY;
        slot_len_nxt[i]   = '0;
        slot_start_nxt[i] = '0;
      end
      held_nxt      = '0;
      cur_class_nxt = CLS_EMPTY;
      cur_len_nxt   = '0;
      cur_start_nxt = '0;
      cr_run_nxt    = '0;
      pos_nxt       = '0;
      done_nxt      = 1'b0;
      cr_inc        = LENGTH_BITS'(1);
    end

    if (!done_nxt) begin
      if (item.has_byte) begin
        pos_nxt = pos_nxt + 1'b1;
        if (item.data_byte == CHR_LF) begin
          finish = 1'b1;
        end else begin
          if (cur_len_nxt == '0 && cr_run_nxt == '0) begin
            cur_class_nxt = classify(item.data_byte);
          end
          if (item.data_byte == CHR_CR) begin
            cr_run_nxt = cr_inc;
          end else begin
            len_sum     = {1'b0, cur_len_nxt} + {1'b0, cr_inc};
            cur_len_nxt = (len_sum > {1'b0, LEN_MAX}) ? LEN_MAX
                                                       : len_sum[LENGTH_BITS-1:0];
            cr_run_nxt  = '0;
          end
        end
      end

      // unterminated last line counts if it has any byte
      if (item.end_of_stream && !finish && (cur_len_nxt != '0 || cr_run_nxt != '0)) begin
        finish = 1'b1;
      end

      if (finish) begin
        if (cur_len_nxt == '0) begin
          cur_class_nxt = CLS_EMPTY;
        end
        if (held_nxt == 2'd3 && slot_class_nxt[0] == CLS_AT &&
            slot_class_nxt[2] == CLS_PLUS && slot_len_nxt[1] == cur_len_nxt) begin
          dec.emit  = 1'b1;
          dec.found = 1'b1;
          dec.sat   = (cur_len_nxt == LEN_MAX);
          rel_start = slot_start_nxt[0];
          done_nxt  = 1'b1;
        end else begin
          if (held_nxt == 2'd3) begin
            slot_class_nxt[0] = slot_class_nxt[1];
            slot_len_nxt[0]   = slot_len_nxt[1];
            slot_start_nxt[0] = slot_start_nxt[1];
            slot_class_nxt[1] = slot_class_nxt[2];
            slot_len_nxt[1]   = slot_len_nxt[2];
            slot_start_nxt[1] = slot_start_nxt[2];
            slot_class_nxt[2] = cur_class_nxt;
            slot_len_nxt[2]   = cur_len_nxt;
            slot_start_nxt[2] = cur_start_nxt;
          end else begin
            slot_class_nxt[held_nxt] = cur_class_nxt;
            slot_len_nxt[held_nxt]   = cur_len_nxt;
            slot_start_nxt[held_nxt] = cur_start_nxt;
            held_nxt                 = held_nxt + 1'b1;
          end
          cur_class_nxt = CLS_EMPTY;
          cur_len_nxt   = '0;
          cur_start_nxt = pos_nxt;
          cr_run_nxt    = '0;
        end
      end

      // end of stream: first header candidate still held decides
      if (item.end_of_stream && !dec.emit) begin
        dec.emit = 1'b1;
        done_nxt = 1'b1;
        if (held_nxt > 2'd0 && slot_class_nxt[0] == CLS_AT) begin
          hit = 1'b1;
          if (held_nxt > 2'd1 && slot_len_nxt[1] != '0) begin
            dec.found = 1'b1;
            rel_start = slot_start_nxt[0];
          end
        end
        if (!hit && held_nxt > 2'd1 && slot_class_nxt[1] == CLS_AT) begin
          hit = 1'b1;
          if (held_nxt > 2'd2 && slot_len_nxt[2] != '0) begin
            dec.found = 1'b1;
            rel_start = slot_start_nxt[1];
          end
        end
        // a candidate in the last held slot has no following line
      end
    end

    if (!fire) begin
      dec.emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        slot_class_r[i] <= CLS_EMPTY;
        slot_len_r[i]   <= '0;
        slot_start_r[i] <= '0;
      end
      held_r      <= '0;
      cur_class_r <= CLS_EMPTY;
      cur_len_r   <= '0;
      cur_start_r <= '0;
      cr_run_r    <= '0;
      pos_r       <= '0;
      done_r      <= 1'b0;
    end else if (fire) begin
      for (int i = 0; i < 3; i++) begin
        slot_class_r[i] <= slot_class_nxt[i];
        slot_len_r[i]   <= slot_len_nxt[i];
        slot_start_r[i] <= slot_start_nxt[i];
      end
      held_r      <= held_nxt;
      cur_class_r <= cur_class_nxt;
      cur_len_r   <= cur_len_nxt;
      cur_start_r <= cur_start_nxt;
      cr_run_r    <= cr_run_nxt;
      pos_r       <= pos_nxt;
      done_r      <= done_nxt;
    end
  end

endmodule

@@ src/fqrb_result_stage.sv @@
// ----------------------------------------------------------------------------
// fqrb_result_stage
// Holds the base offset register, forms the absolute offset and keeps the
// result in an output register until the consumer takes it.
// ----------------------------------------------------------------------------
module fqrb_result_stage #(
  parameter int OFFSET_BITS = fqrb_pkg::OFFSET_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [fqrb_pkg::OFFSET_W-1:0]     cfg_wdata,
  input  fqrb_pkg::decide_t                 dec,
  input  logic [OFFSET_BITS-1:0]            rel_start,
  output logic                              can_take,
  output logic                              out_valid,
  input  logic                              out_ready,
  output fqrb_pkg::out_item_t               out_data
);
  import fqrb_pkg::*;

  logic [OFFSET_W-1:0]    base_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;
  logic [OFFSET_BITS-1:0] abs_sum;

  // offset wraps at the configured offset width
  assign abs_sum  = OFFSET_BITS'(base_r) + rel_start;
  assign can_take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
      if (dec.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dec.emit) begin
      out_data_r.found            <= dec.found;
      out_data_r.record_offset    <= dec.found ? OFFSET_W'(abs_sum) : '0;
      out_data_r.length_saturated <= dec.found && dec.sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/sv/fastq_record_boundary_finder_tb.sv @@
// ----------------------------------------------------------------------------
// fastq_record_boundary_finder_tb
// Feeds byte streams through the record boundary finder and checks every
// result against a cycle-free model of the line window. Hand-written streams
// cover the record layouts and end-of-stream rules. Random FASTQ-like scans
// run under three idle profiles.
// ----------------------------------------------------------------------------
module fastq_record_boundary_finder_tb;
  import fqrb_pkg::*;

  localparam int LEN_W = LENGTH_BITS_DEF;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [7:0] NEWLINE = 8'h0A;
  localparam logic [7:0] CARRIAGE_RETURN = 8'h0D;
  localparam logic [7:0] AT_SIGN = 8'h40;
  localparam logic [7:0] PLUS_SIGN = 8'h2B;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [OFFSET_W-1:0] cfg_wdata = '0;

  // model of the line window
  line_class_t win_class [4];
  logic [LEN_W-1:0] win_len [4];
  logic [OFFSET_W-1:0] win_start [4];
  logic [2:0] lines_held;
  logic [OFFSET_W-1:0] scan_pos;
  logic [LEN_W-1:0] cr_run;
  bit scan_over;
  logic [OFFSET_W-1:0] base_offset;

  out_item_t expected_results [$];
  logic [7:0] scan_bytes [$];

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  bit hold_pending = 1'b0;
  int mismatches = 0;
  int items_taken = 0;
  int scans_started = 0;
  int results_checked = 0;
  int records_found = 0;
  int saturated_results = 0;
  int idle_cycles = 0;

  fastq_record_boundary_finder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [LEN_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[LEN_W] ? LEN_MAX : sum[LEN_W-1:0];
  endfunction

  function automatic void clear_window();
    int k;
    for (k = 0; k < 4; k++) begin
      win_class[k] = CLS_EMPTY;
      win_len[k] = '0;
      win_start[k] = '0;
    end
    lines_held = '0;
    scan_pos = '0;
    cr_run = '0;
    scan_over = 1'b0;
  endfunction

  function automatic void expect_result(input logic found, input logic [OFFSET_W-1:0] rel,
                                        input logic sat);
    out_item_t r;
    r.found = found;
    r.record_offset = found ? base_offset + rel : '0;
    r.length_saturated = found & sat;
    expected_results.push_back(r);
    scan_over = 1'b1;
  endfunction

  // closes the line being received; 1 when the oldest line proves to be a header
  function automatic bit close_line();
    int k;
    if (win_len[lines_held[1:0]] == '0)
      win_class[lines_held[1:0]] = CLS_EMPTY;
    lines_held++;
    if (lines_held == 3'd4) begin
      if (win_class[0] == CLS_AT && win_class[2] == CLS_PLUS && win_len[1] == win_len[3]) begin
        expect_result(1'b1, win_start[0], win_len[1] == LEN_MAX || win_len[3] == LEN_MAX);
        return 1'b1;
      end
      for (k = 0; k < 3; k++) begin
        win_class[k] = win_class[k+1];
        win_len[k] = win_len[k+1];
        win_start[k] = win_start[k+1];
      end
      lines_held = 3'd3;
    end
    win_class[lines_held[1:0]] = CLS_EMPTY;
    win_len[lines_held[1:0]] = '0;
    win_start[lines_held[1:0]] = scan_pos;
    cr_run = '0;
    return 1'b0;
  endfunction

  // first header candidate still held decides at end of stream
  function automatic void decide_at_end();
    int k;
    for (k = 0; k < lines_held; k++) begin
      if (win_class[k] == CLS_AT) begin
        if (k + 1 >= lines_held || win_len[k+1] == '0)
          expect_result(1'b0, '0, 1'b0);
        else
          expect_result(1'b1, win_start[k], 1'b0);
        return;
      end
    end
    expect_result(1'b0, '0, 1'b0);
  endfunction

  // returns 0 when the block ignores the transaction
  function automatic bit take_item(input in_item_t item);
    logic [1:0] cur;
    if (item.start_scan) begin
      clear_window();
      scans_started++;
    end
    if (scan_over)
      return 1'b0;
    if (item.has_byte) begin
      cur = lines_held[1:0];
      scan_pos++;
      if (item.data_byte == NEWLINE) begin
        if (close_line())
          return 1'b1;
      end else begin
        if (win_len[cur] == '0 && cr_run == '0)
          win_class[cur] = (item.data_byte == AT_SIGN) ? CLS_AT :
                           (item.data_byte == PLUS_SIGN) ? CLS_PLUS : CLS_OTHER;
        if (item.data_byte == CARRIAGE_RETURN) begin
          cr_run = sat_add(cr_run, LEN_W'(1));
        end else begin
          win_len[cur] = sat_add(win_len[cur], sat_add(cr_run, LEN_W'(1)));
          cr_run = '0;
        end
      end
    end
    if (item.end_of_stream) begin
      if (win_len[lines_held[1:0]] != '0 || cr_run != '0) begin
        if (close_line())
          return 1'b1;
      end
      decide_at_end();
    end
    return 1'b1;
  endfunction

  function automatic in_item_t pack_item(input logic [7:0] b, input logic has,
                                         input logic eos, input logic start);
    in_item_t item;
    item.data_byte = b;
    item.has_byte = has;
    item.end_of_stream = eos;
    item.start_scan = start;
    return item;
  endfunction

  function automatic logic [7:0] text_byte();
    string letters;
    logic [7:0] b;
    letters = "ACGTN";
    if ($urandom_range(0, 4) != 0) begin
      b = letters[$urandom_range(0, 4)];
    end else begin
      b = 8'($urandom_range(0, 255));
      if (b == NEWLINE)
        b = "N";
    end
    return b;
  endfunction

  function automatic void push_text(input int n);
    repeat (n) scan_bytes.push_back(text_byte());
  endfunction

  function automatic void push_line_end();
    case ($urandom_range(0, 9))
      0: begin
        scan_bytes.push_back(CARRIAGE_RETURN);
        scan_bytes.push_back(CARRIAGE_RETURN);
      end
      1, 2: scan_bytes.push_back(CARRIAGE_RETURN);
      default: ;
    endcase
    scan_bytes.push_back(NEWLINE);
  endfunction

  task automatic report_mismatch(input string what, input logic [OFFSET_W-1:0] got,
                                 input logic [OFFSET_W-1:0] want);
    mismatches++;
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic send_item(input in_item_t item);
    @(negedge clk);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    if (take_item(item))
      items_taken++;
  endtask

  task automatic send_text(input string s, input bit start, input bit eos);
    int i;
    if (s.len() == 0) begin
      send_item(pack_item(8'h00, 1'b0, eos, start));
    end else begin
      for (i = 0; i < s.len(); i++)
        send_item(pack_item(s[i], 1'b1, eos && i == s.len() - 1, start && i == 0));
    end
  endtask

  task automatic wait_block_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_base_offset(input logic [OFFSET_W-1:0] value);
    wait_block_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    base_offset = value;
  endtask

  // "\015" is a carriage return
  task automatic test_record_layouts();
    send_text("@r1\nACGT\n+\nIIII\n", 1'b0, 1'b0);
    send_text("@x\n", 1'b0, 1'b1);
    send_text("zz\n@a\nAC\n+\nII\n", 1'b1, 1'b0);
    send_text("@a\015\nAC\015\n+\015\nII\015\n", 1'b1, 1'b0);
    send_text("\015\015\n@a\nA\n+\nI\n", 1'b1, 1'b0);
    send_text("\015@a\nA\n+\nI\nx", 1'b1, 1'b1);
    send_text("@a\nACG\n+\nII\n", 1'b1, 1'b1);
    send_text("x\n@h", 1'b1, 1'b1);
    send_text("@h\n\n", 1'b1, 1'b1);
    send_text("@h\nAC", 1'b1, 1'b1);
    send_text("@h\nA\015", 1'b1, 1'b1);
    send_text("", 1'b1, 1'b1);
    send_text("+x\n@@\n\n+\n\n", 1'b1, 1'b0);
    send_text("@q\nA", 1'b1, 1'b0);
    send_item(pack_item(8'h5A, 1'b0, 1'b0, 1'b0));
    send_text("\n+\nB\n", 1'b0, 1'b0);
    // abandoned by a restart
    send_text("@a\nAC\n+", 1'b1, 1'b0);
    send_item(pack_item(8'h00, 1'b1, 1'b0, 1'b1));
    send_item(pack_item(8'hFF, 1'b1, 1'b0, 1'b0));
    send_text("\n@b\nA\n+\nC\n", 1'b0, 1'b0);
    send_item(pack_item(8'hA5, 1'b0, 1'b0, 1'b1));
    send_text("@s\nA\n+\nB\n", 1'b0, 1'b0);
  endtask

  task automatic test_base_offset_wrap();
    set_base_offset('1);
    send_text("ab\n@c\nA\n+\nI\n", 1'b1, 1'b0);
    set_base_offset(48'hFFFF_FFFF_FFFD);
    send_text("ab\n@c\nA\n+\nI\n", 1'b1, 1'b0);
    send_text("ab\n@c\nAG", 1'b1, 1'b1);
  endtask

  // output held off long enough that the block stalls its input
  task automatic test_result_backpressure();
    hold_pending = 1'b1;
    repeat (5) send_text("@\nA\n+\nA\n", 1'b1, 1'b0);
  endtask

  task automatic send_random_scan();
    int seq_len, qual_len, cut, i, ending;
    scan_bytes.delete();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0: scan_bytes.push_back(AT_SIGN);
        1: scan_bytes.push_back(PLUS_SIGN);
        default: ;
      endcase
      push_text($urandom_range(0, 5));
      push_line_end();
    end
    seq_len = $urandom_range(0, 8);
    qual_len = seq_len;
    case ($urandom_range(0, 9))
      0: qual_len = seq_len + 1;
      1: if (seq_len > 0) qual_len = seq_len - 1;
      default: ;
    endcase
    scan_bytes.push_back(AT_SIGN);
    push_text($urandom_range(0, 4));
    push_line_end();
    push_text(seq_len);
    push_line_end();
    scan_bytes.push_back(PLUS_SIGN);
    if ($urandom_range(0, 3) == 0)
      push_text($urandom_range(1, 4));
    push_line_end();
    push_text(qual_len);
    if ($urandom_range(0, 3) != 0)
      push_line_end();
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, scan_bytes.size());
      repeat (cut) scan_bytes.delete(scan_bytes.size() - 1);
    end

    // 0 abandons the scan, 1..9 flag end on the last byte, else a bare end marker
    ending = $urandom_range(0, 19);
    for (i = 0; i < scan_bytes.size(); i++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(pack_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0));
      send_item(pack_item(scan_bytes[i], 1'b1,
                          ending >= 1 && ending <= 9 && i == scan_bytes.size() - 1, i == 0));
    end
    if (ending >= 10 || (ending != 0 && scan_bytes.size() == 0))
      send_item(pack_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, scan_bytes.size() == 0));
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3))
        send_item(pack_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'b0));
    end
  endtask

  task automatic test_random_scans(input int n_items, input logic [OFFSET_W-1:0] base);
    int first;
    set_base_offset(base);
    first = items_taken;
    while (items_taken - first < n_items) send_random_scan();
  endtask

  // result receiver
  initial begin
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with none expected", out_data.record_offset, '0);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (want.found)
          records_found++;
        if (want.length_saturated)
          saturated_results++;
        if (out_data.found !== want.found)
          report_mismatch("found", OFFSET_W'(out_data.found), OFFSET_W'(want.found));
        if (out_data.record_offset !== want.record_offset)
          report_mismatch("record_offset", out_data.record_offset, want.record_offset);
        if (out_data.length_saturated !== want.length_saturated)
          report_mismatch("length_saturated", OFFSET_W'(out_data.length_saturated),
                          OFFSET_W'(want.length_saturated));
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles with no transaction", WATCHDOG_LIMIT);
      $display("fastq_record_boundary_finder test failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] wide;
    clear_window();
    base_offset = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 18;
    receiver_idle_pct = 60;
    test_record_layouts();
    test_result_backpressure();
    test_base_offset_wrap();
    wide = {$urandom, $urandom};
    test_random_scans(450, wide[OFFSET_W-1:0]);

    sender_idle_pct = 60;
    receiver_idle_pct = 18;
    test_random_scans(450, 48'hFFFF_FFFF_FF00);

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_random_scans(450, '0);

    wait_block_idle();
    repeat (8) @(posedge clk);
    $display("run covered %0d transactions in %0d scans, with a long output stall",
             items_taken, scans_started);
    $display("%0d results checked, %0d with a record found, %0d flagged saturated",
             results_checked, records_found, saturated_results);
    if (mismatches == 0)
      $display("fastq_record_boundary_finder test passed");
    else
      $display("fastq_record_boundary_finder test failed");
    $finish;
  end

endmodule

@@ fastq_record_boundary_finder.f @@
src/fqrb_pkg.sv
src/fqrb_scan_core.sv
src/fqrb_result_stage.sv
src/fastq_record_boundary_finder.sv
tb/sv/fastq_record_boundary_finder_tb.sv
